### sv/assert_macros.svh
// assertion macros shared by the compose unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define WMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define WMC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

### sv/wmc_pkg.sv
// types, constants and arithmetic helpers of the world matrix compose unit
package wmc_pkg;

  typedef logic signed [33:0] q_t;
  typedef logic signed [35:0] ang_t;
  typedef logic signed [67:0] prod_t;
  typedef logic signed [31:0] elem_t;

  localparam q_t    Q30_ONE     = 34'sd1073741824;
  localparam ang_t  PI_Q30      = 36'sd3373259426;
  localparam ang_t  HALF_PI_Q30 = 36'sd1686629713;
  localparam ang_t  TWO_PI_Q30  = 36'sd6746518852;
  localparam elem_t ELEM_ONE    = 32'sd65536;

  localparam int SIN_STEPS  = 5;
  localparam int COS_STEPS  = 6;
  localparam int NUM_ANGLES = 3;
  localparam int LAST_TERM  = 22;
  localparam int ELEM_BASE  = 14;
  localparam logic [1:0] LAST_ROW = 2'd3;

  typedef struct packed {
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    q_t                 ang_x;
    q_t                 ang_y;
    q_t                 ang_z;
    logic [2:0]         cneg;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic signed [23:0] offset_z;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic start;
    q_t   x;
    logic cneg;
  } trig_req_t;

  typedef struct packed {
    logic done;
    q_t   s;
    q_t   c;
  } trig_resp_t;

  typedef struct packed {
    elem_t e0;
    elem_t e1;
    elem_t e2;
  } row_t;

  typedef enum logic [3:0] {
    T_IDLE, T_SQ, T_SQR, T_MUL, T_RND, T_DIV, T_UPD, T_SMUL, T_SFIN, T_CFIN
  } trig_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_TSTART, B_TWAIT, B_MAT, B_DRAIN, B_HOLD
  } back_state_t;

  // round to nearest, ties away from zero
  function automatic prod_t rnd_sh(input prod_t v, input int unsigned sh);
    logic [67:0] mag;
    logic [67:0] r;
    mag = v[67] ? 68'(-v) : 68'(v);
    r = (mag + (68'd1 << (sh - 1))) >> sh;
    return v[67] ? -$signed(r) : $signed(r);
  endfunction

  function automatic q_t clamp_unit(input q_t v);
    if (v > Q30_ONE) return Q30_ONE;
    if (v < -Q30_ONE) return -Q30_ONE;
    return v;
  endfunction

  function automatic elem_t sat32(input prod_t v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return elem_t'(v);
  endfunction

  // horner step divisors k*(k+1) as reciprocals, exact for 32 bit dividends
  function automatic logic [32:0] div_recip(input logic cos_chain, input logic [2:0] step);
    logic [32:0] m;
    m = 33'd4294967296;
    if (!cos_chain) begin
      unique case (step)
        3'd0: m = 33'd4997780127;
        3'd1: m = 33'd7635497416;
        3'd2: m = 33'd6544712071;
        3'd3: m = 33'd6871947674;
        default: m = 33'd5726623062;
      endcase
    end else begin
      unique case (step)
        3'd0: m = 33'd8329633544;
        3'd1: m = 33'd6108397933;
        3'd2: m = 33'd4908534053;
        3'd3: m = 33'd4581298450;
        3'd4: m = 33'd5726623062;
        default: m = 33'd4294967296;
      endcase
    end
    return m;
  endfunction

  // shift that goes with each reciprocal
  function automatic logic [5:0] div_shift(input logic cos_chain, input logic [2:0] step);
    logic [5:0] s;
    s = 6'd33;
    if (!cos_chain) begin
      unique case (step)
        3'd0: s = 6'd39;
        3'd1: s = 6'd39;
        3'd2: s = 6'd38;
        3'd3: s = 6'd37;
        default: s = 6'd35;
      endcase
    end else begin
      unique case (step)
        3'd0: s = 6'd40;
        3'd1: s = 6'd39;
        3'd2: s = 6'd38;
        3'd3: s = 6'd37;
        3'd4: s = 6'd36;
        default: s = 6'd33;
      endcase
    end
    return s;
  endfunction

endpackage

### sv/world_matrix_compose_unit.sv
// world matrix compose unit top level
//
//  channel | direction | beat contents
//  in_     | input     | scale xyz (Q8.8), angles xyz (Q4.12), offsets xyz (Q16.8)
//  out_    | output    | row index, four Q16.16 elements, last row flag
//
// in the back end each angle of an item passes through the trig unit (squaring,
// 11 horner steps of multiply, round, divide and update, sine product)
// the matrix products then run on one shared multiplier
// the queue keeps taking items while the back end works; rows leave one per beat
// rst_n is synchronous, active low; out_stall holds the current row
module world_matrix_compose_unit import wmc_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_scale_x,
  input  logic signed [15:0] in_scale_y,
  input  logic signed [15:0] in_scale_z,
  input  logic signed [15:0] in_angle_x,
  input  logic signed [15:0] in_angle_y,
  input  logic signed [15:0] in_angle_z,
  input  logic signed [23:0] in_offset_x,
  input  logic signed [23:0] in_offset_y,
  input  logic signed [23:0] in_offset_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_elem_0,
  output logic signed [31:0] out_elem_1,
  output logic signed [31:0] out_elem_2,
  output logic signed [31:0] out_elem_3,
  output logic               out_last_row
);

  fifo_stat_t q_stat;
  logic       q_push, q_pop;
  item_t      q_wr, q_rd;
  trig_req_t  trig_req;
  trig_resp_t trig_resp;

  wmc_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_scale_x (in_scale_x),
    .in_scale_y (in_scale_y),
    .in_scale_z (in_scale_z),
    .in_angle_x (in_angle_x),
    .in_angle_y (in_angle_y),
    .in_angle_z (in_angle_z),
    .in_offset_x(in_offset_x),
    .in_offset_y(in_offset_y),
    .in_offset_z(in_offset_z),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_data     (q_wr)
  );

  wmc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data(q_wr),
    .pop    (q_pop),
    .rd_data(q_rd),
    .stat   (q_stat)
  );

  wmc_trig u_trig (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (trig_req),
    .resp (trig_resp)
  );

  wmc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_data       (q_rd),
    .q_stat       (q_stat),
    .q_pop        (q_pop),
    .trig_req     (trig_req),
    .trig_resp    (trig_resp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row_index(out_row_index),
    .out_elem_0   (out_elem_0),
    .out_elem_1   (out_elem_1),
    .out_elem_2   (out_elem_2),
    .out_elem_3   (out_elem_3),
    .out_last_row (out_last_row)
  );

endmodule

### sv/wmc_front.sv
// front end: accepts input beats and folds angles into the range -pi/2 to pi/2
module wmc_front import wmc_pkg::*; (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_scale_x,
  input  logic signed [15:0] in_scale_y,
  input  logic signed [15:0] in_scale_z,
  input  logic signed [15:0] in_angle_x,
  input  logic signed [15:0] in_angle_y,
  input  logic signed [15:0] in_angle_z,
  input  logic signed [23:0] in_offset_x,
  input  logic signed [23:0] in_offset_y,
  input  logic signed [23:0] in_offset_z,
  input  fifo_stat_t         q_stat,
  output logic               q_push,
  output item_t              q_data
);

  function automatic logic [34:0] fold(input logic signed [15:0] a);
    ang_t x0;
    ang_t x1;
    ang_t x2;
    logic neg;
    x0 = {{2{a[15]}}, a, 18'd0};
    x1 = x0;
    if (x0 > PI_Q30) x1 = x0 - TWO_PI_Q30;
    else if (x0 < -PI_Q30) x1 = x0 + TWO_PI_Q30;
    x2 = x1;
    neg = 1'b0;
    if (x1 > HALF_PI_Q30) begin
      x2 = PI_Q30 - x1;
      neg = 1'b1;
    end else if (x1 < -HALF_PI_Q30) begin
      x2 = -PI_Q30 - x1;
      neg = 1'b1;
    end
    return {neg, x2[33:0]};
  endfunction

  logic [34:0] fx, fy, fz;

  assign fx = fold(in_angle_x);
  assign fy = fold(in_angle_y);
  assign fz = fold(in_angle_z);

  assign in_stall = q_stat.full;
  assign q_push   = in_valid & ~q_stat.full;

  always_comb begin
    q_data.scale_x  = in_scale_x;
    q_data.scale_y  = in_scale_y;
    q_data.scale_z  = in_scale_z;
    q_data.ang_x    = q_t'(fx[33:0]);
    q_data.ang_y    = q_t'(fy[33:0]);
    q_data.ang_z    = q_t'(fz[33:0]);
    q_data.cneg     = {fz[34], fy[34], fx[34]};
    q_data.offset_x = in_offset_x;
    q_data.offset_y = in_offset_y;
    q_data.offset_z = in_offset_z;
  end

endmodule

### sv/wmc_fifo.sv
// item queue between front and back
`include "assert_macros.svh"
module wmc_fifo import wmc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  item_t      wr_data,
  input  logic       pop,
  output item_t      rd_data,
  output fifo_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_data    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= inc(wr_ptr_r);
      if (pop) rd_ptr_r <= inc(rd_ptr_r);
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  `WMC_ASSERT(a_fifo_no_ovf, !(push && stat.full), "queue push while full")
  `WMC_ASSERT(a_fifo_no_unf, !(pop && stat.empty), "queue pop while empty")
  `WMC_ASSERT(a_fifo_count, count_r <= CW'(DEPTH), "queue count beyond depth")

endmodule

### sv/wmc_trig.sv
// iterative sine and cosine unit, horner series with reciprocal step division
module wmc_trig import wmc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  trig_req_t  req,
  output trig_resp_t resp
);

  trig_state_t state_r, state_nxt;
  logic [2:0]  step_r;
  logic        cos_r;

  q_t          x_r, x2_r, t_r, s_r;
  logic        cneg_r;
  prod_t       prod_r;
  logic        dneg_r;
  logic [31:0] dmag_r;
  logic [64:0] dprod_r;

  prod_t       v;
  logic [32:0] dvr;
  logic [5:0]  dsh;
  logic [31:0] quo;
  q_t          qs;
  q_t          cl;
  logic [2:0]  last_step;

  assign v         = rnd_sh(prod_r, 30);
  assign dvr       = div_recip(cos_r, step_r);
  assign dsh       = div_shift(cos_r, step_r);
  assign quo       = 32'(dprod_r >> dsh);
  assign qs        = dneg_r ? -q_t'(quo) : q_t'(quo);
  assign cl        = clamp_unit(t_r);
  assign last_step = cos_r ? 3'(COS_STEPS - 1) : 3'(SIN_STEPS - 1);

  assign resp.done = (state_r == T_CFIN);
  assign resp.s    = s_r;
  assign resp.c    = cneg_r ? -cl : cl;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: if (req.start) state_nxt = T_SQ;
      T_SQ:   state_nxt = T_SQR;
      T_SQR:  state_nxt = T_MUL;
      T_MUL:  state_nxt = T_RND;
      T_RND:  state_nxt = T_DIV;
      T_DIV:  state_nxt = T_UPD;
      T_UPD: begin
        if (step_r != last_step) state_nxt = T_MUL;
        else if (cos_r) state_nxt = T_CFIN;
        else state_nxt = T_SMUL;
      end
      T_SMUL: state_nxt = T_SFIN;
      T_SFIN: state_nxt = T_MUL;
      T_CFIN: state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      step_r  <= '0;
      cos_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == T_SQR) begin
        step_r <= '0;
        cos_r  <= 1'b0;
      end
      if (state_r == T_SFIN) begin
        step_r <= '0;
        cos_r  <= 1'b1;
      end
      if (state_r == T_UPD && step_r != last_step) step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      T_IDLE: begin
        if (req.start) begin
          x_r    <= req.x;
          cneg_r <= req.cneg;
        end
      end
      T_SQ:  prod_r <= x_r * x_r;
      T_SQR: begin
        x2_r <= q_t'(v);
        t_r  <= Q30_ONE;
      end
      T_MUL: prod_r <= x2_r * t_r;
      T_RND: begin
        dneg_r <= v[67];
        dmag_r <= v[67] ? 32'(-v) : 32'(v);
      end
      T_DIV:  dprod_r <= dmag_r * dvr;
      T_UPD:  t_r <= Q30_ONE - qs;
      T_SMUL: prod_r <= x_r * t_r;
      T_SFIN: begin
        s_r <= clamp_unit(q_t'(v));
        t_r <= Q30_ONE;
      end
      default: ;
    endcase
  end

endmodule

### sv/wmc_back.sv
// back end: runs the angles through the trig unit, composes the matrix, sends rows
`include "assert_macros.svh"
module wmc_back import wmc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  item_t              q_data,
  input  fifo_stat_t         q_stat,
  output logic               q_pop,
  output trig_req_t          trig_req,
  input  trig_resp_t         trig_resp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_elem_0,
  output logic signed [31:0] out_elem_1,
  output logic signed [31:0] out_elem_2,
  output logic signed [31:0] out_elem_3,
  output logic               out_last_row
);

  back_state_t state_r, state_nxt;
  item_t       item_r;
  logic [1:0]  ai_r;
  logic [4:0]  term_r;
  logic        issue;

  q_t sx_r, cx_r, sy_r, cy_r, sz_r, cz_r;
  q_t a01_r, a02_r, a11_r, a12_r;
  q_t r00_r, r02_r, r10_r, r12_r, r20_r, r22_r;
  q_t opa, opb;
  q_t sc0, sc1, sc2;

  prod_t      prod_r, acc_r;
  logic       p_vld_r, a_vld_r;
  logic [4:0] p_term_r, a_term_r;
  elem_t      e_r [9];
  logic [3:0] e_idx;

  logic       bank_vld_r;
  logic [1:0] row_r;
  row_t       bank_r [3];
  logic signed [23:0] boff_x_r, boff_y_r, boff_z_r;
  logic       take;
  logic       is_last;

  function automatic logic term_first(input logic [4:0] t);
    return !(t == 5'd7 || t == 5'd9 || t == 5'd11 || t == 5'd13);
  endfunction

  function automatic logic term_last(input logic [4:0] t);
    return !(t == 5'd6 || t == 5'd8 || t == 5'd10 || t == 5'd12);
  endfunction

  assign sc0   = q_t'(item_r.scale_x);
  assign sc1   = q_t'(item_r.scale_y);
  assign sc2   = q_t'(item_r.scale_z);
  assign e_idx = 4'(a_term_r - 5'(ELEM_BASE));

  always_comb begin
    state_nxt      = state_r;
    q_pop          = 1'b0;
    issue          = 1'b0;
    trig_req.start = 1'b0;
    unique case (ai_r)
      2'd0: begin
        trig_req.x    = item_r.ang_x;
        trig_req.cneg = item_r.cneg[0];
      end
      2'd1: begin
        trig_req.x    = item_r.ang_y;
        trig_req.cneg = item_r.cneg[1];
      end
      default: begin
        trig_req.x    = item_r.ang_z;
        trig_req.cneg = item_r.cneg[2];
      end
    endcase
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          state_nxt = B_TSTART;
        end
      end
      B_TSTART: begin
        trig_req.start = 1'b1;
        state_nxt      = B_TWAIT;
      end
      B_TWAIT: begin
        if (trig_resp.done) begin
          state_nxt = (ai_r == 2'(NUM_ANGLES - 1)) ? B_MAT : B_TSTART;
        end
      end
      B_MAT: begin
        issue = 1'b1;
        if (term_r == 5'(LAST_TERM)) state_nxt = B_DRAIN;
      end
      B_DRAIN: if (!p_vld_r && !a_vld_r) state_nxt = B_HOLD;
      B_HOLD:  if (!bank_vld_r) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // multiply schedule: rz*rx, then *ry, then the scale rows
  always_comb begin
    opa = sz_r;
    opb = cx_r;
    unique case (term_r)
      5'd0:  begin opa = sz_r;  opb = cx_r;  end
      5'd1:  begin opa = sz_r;  opb = sx_r;  end
      5'd2:  begin opa = cz_r;  opb = cx_r;  end
      5'd3:  begin opa = cz_r;  opb = sx_r;  end
      5'd4:  begin opa = cx_r;  opb = sy_r;  end
      5'd5:  begin opa = cx_r;  opb = cy_r;  end
      5'd6:  begin opa = cz_r;  opb = cy_r;  end
      5'd7:  begin opa = a02_r; opb = sy_r;  end
      5'd8:  begin opa = -cz_r; opb = sy_r;  end
      5'd9:  begin opa = a02_r; opb = cy_r;  end
      5'd10: begin opa = -sz_r; opb = cy_r;  end
      5'd11: begin opa = a12_r; opb = sy_r;  end
      5'd12: begin opa = sz_r;  opb = sy_r;  end
      5'd13: begin opa = a12_r; opb = cy_r;  end
      5'd14: begin opa = sc0;   opb = r00_r; end
      5'd15: begin opa = sc0;   opb = a01_r; end
      5'd16: begin opa = sc0;   opb = r02_r; end
      5'd17: begin opa = sc1;   opb = r10_r; end
      5'd18: begin opa = sc1;   opb = a11_r; end
      5'd19: begin opa = sc1;   opb = r12_r; end
      5'd20: begin opa = sc2;   opb = r20_r; end
      5'd21: begin opa = sc2;   opb = -sx_r; end
      5'd22: begin opa = sc2;   opb = r22_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ai_r    <= '0;
      term_r  <= '0;
      p_vld_r <= 1'b0;
      a_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_IDLE) begin
        ai_r   <= '0;
        term_r <= '0;
      end
      if (state_r == B_TWAIT && trig_resp.done) ai_r <= ai_r + 1'b1;
      if (issue) term_r <= term_r + 1'b1;
      p_vld_r <= issue;
      a_vld_r <= p_vld_r & term_last(p_term_r);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_data;
    if (state_r == B_TWAIT && trig_resp.done) begin
      unique case (ai_r)
        2'd0: begin
          sx_r <= trig_resp.s;
          cx_r <= trig_resp.c;
        end
        2'd1: begin
          sy_r <= trig_resp.s;
          cy_r <= trig_resp.c;
        end
        default: begin
          sz_r <= trig_resp.s;
          cz_r <= trig_resp.c;
        end
      endcase
    end
    if (issue) begin
      prod_r   <= opa * opb;
      p_term_r <= term_r;
    end
    if (p_vld_r) begin
      acc_r    <= term_first(p_term_r) ? prod_r : acc_r + prod_r;
      a_term_r <= p_term_r;
    end
    if (a_vld_r) begin
      unique case (a_term_r)
        5'd0:  a01_r <= q_t'(rnd_sh(acc_r, 30));
        5'd1:  a02_r <= q_t'(rnd_sh(acc_r, 30));
        5'd2:  a11_r <= q_t'(rnd_sh(acc_r, 30));
        5'd3:  a12_r <= q_t'(rnd_sh(acc_r, 30));
        5'd4:  r20_r <= q_t'(rnd_sh(acc_r, 30));
        5'd5:  r22_r <= q_t'(rnd_sh(acc_r, 30));
        5'd7:  r00_r <= q_t'(rnd_sh(acc_r, 30));
        5'd9:  r02_r <= q_t'(rnd_sh(acc_r, 30));
        5'd11: r10_r <= q_t'(rnd_sh(acc_r, 30));
        5'd13: r12_r <= q_t'(rnd_sh(acc_r, 30));
        default: begin
          if (a_term_r >= 5'(ELEM_BASE)) e_r[e_idx] <= sat32(rnd_sh(acc_r, 22));
        end
      endcase
    end
  end

  // output bank, rows shift toward the port
  assign take    = bank_vld_r & ~out_stall;
  assign is_last = (row_r == LAST_ROW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_vld_r <= 1'b0;
      row_r      <= '0;
    end else begin
      if (state_r == B_HOLD && !bank_vld_r) begin
        bank_vld_r <= 1'b1;
        row_r      <= '0;
      end else if (take) begin
        if (is_last) bank_vld_r <= 1'b0;
        row_r <= row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_HOLD && !bank_vld_r) begin
      bank_r[0] <= '{e0: e_r[0], e1: e_r[1], e2: e_r[2]};
      bank_r[1] <= '{e0: e_r[3], e1: e_r[4], e2: e_r[5]};
      bank_r[2] <= '{e0: e_r[6], e1: e_r[7], e2: e_r[8]};
      boff_x_r  <= item_r.offset_x;
      boff_y_r  <= item_r.offset_y;
      boff_z_r  <= item_r.offset_z;
    end else if (take) begin
      bank_r[0] <= bank_r[1];
      bank_r[1] <= bank_r[2];
    end
  end

  assign out_valid     = bank_vld_r;
  assign out_row_index = row_r;
  assign out_last_row  = is_last;
  assign out_elem_0    = is_last ? {boff_x_r, 8'd0} : bank_r[0].e0;
  assign out_elem_1    = is_last ? {boff_y_r, 8'd0} : bank_r[0].e1;
  assign out_elem_2    = is_last ? {boff_z_r, 8'd0} : bank_r[0].e2;
  assign out_elem_3    = is_last ? ELEM_ONE : '0;

  `WMC_ASSERT(a_back_done, !trig_resp.done || state_r == B_TWAIT, "trig result while not waiting")
  `WMC_ASSERT(a_back_pipe, !(p_vld_r || a_vld_r) || state_r == B_MAT || state_r == B_DRAIN, "mac pipe busy outside matrix phase")
  `WMC_ASSERT_NEXT(a_back_load, (state_r == B_HOLD && !bank_vld_r), bank_vld_r, "bank not loaded")

endmodule
